FILE: design/vwbp_pkg.sv
// Shared types, constants and helpers for the variable width bit packer.
package vwbp_pkg;

  localparam int WordBits = 64;
  localparam int FieldW   = 64;
  localparam int CountW   = 7;
  localparam int PosW     = $clog2(WordBits + 1);
  localparam int PaddrW   = 3;
  localparam int PdataW   = 32;

  typedef logic [FieldW-1:0]   field_t;
  typedef logic [WordBits-1:0] word_t;
  typedef logic [CountW-1:0]   count_t;
  typedef logic [PosW-1:0]     pos_t;
  typedef logic [PaddrW-3:0]   reg_idx_t;
  typedef logic [PdataW-1:0]   pdata_t;

  // Register index codes
  localparam reg_idx_t RegPackMode = reg_idx_t'(0);

  localparam count_t WordCount = count_t'(WordBits);

  typedef struct packed {
    count_t bit_count;
    field_t write_value;
    field_t next_word;
    logic   flush_request;
  } item_t;

  typedef struct packed {
    logic   status;
    field_t word_out;
    logic   word_out_valid;
    field_t read_value;
    logic   word_consumed;
  } result_t;

  typedef struct packed {
    word_t bit_buffer;
    pos_t  bit_position;
  } state_t;

  // Configuration control from the register port to the datapath
  typedef struct packed {
    logic init;
    logic next_pack;
    logic pack_mode;
  } cfg_t;

  // Ones in the low n bits; all ones once n reaches the field width
  function automatic field_t low_mask(count_t n);
    return ~({FieldW{1'b1}} << n);
  endfunction

  // Empty state for the given mode: unpacking starts with a drained buffer
  function automatic state_t init_state(logic pack);
    state_t s;
    s.bit_buffer   = '0;
    s.bit_position = pack ? '0 : pos_t'(WordBits);
    return s;
  endfunction

endpackage

FILE: design/variable_width_bit_packer.sv
// An accepted word is held in the input register, then its result is written to the result register,
// from which it is taken at the output handshake.
// Throughput: one word per cycle while the result is taken; the buffer and position update in one step.
// A stalled result holds the result register; the input register still takes one more word,
// then the input stalls until the result is taken. Reset selects pack mode with an empty
// buffer; a mode write re-initialises the buffer (position 0 to pack, full word to unpack).
module variable_width_bit_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vwbp_pkg::PaddrW-1:0] paddr,
  input  vwbp_pkg::pdata_t            pwdata,
  output vwbp_pkg::pdata_t            prdata,
  output logic                        pready,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  vwbp_pkg::count_t            bit_count_i,
  input  logic [63:0]                 write_value_i,
  input  logic [63:0]                 next_word_i,
  input  logic                        flush_request_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        status_o,
  output logic [63:0]                 word_out_o,
  output logic                        word_out_valid_o,
  output logic [63:0]                 read_value_o,
  output logic                        word_consumed_o
);

  vwbp_pkg::cfg_t    cfg;
  vwbp_pkg::item_t   item_d;
  vwbp_pkg::item_t   item_q;
  logic              s1_valid_q;
  logic              out_valid_q;
  vwbp_pkg::result_t res_d;
  vwbp_pkg::result_t res_q;
  vwbp_pkg::state_t  state_d;
  vwbp_pkg::state_t  state_q;
  logic              advance;

  vwbp_apb u_apb (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Gather the input word
  assign item_d.bit_count     = bit_count_i;
  assign item_d.write_value   = vwbp_pkg::field_t'(write_value_i);
  assign item_d.next_word     = vwbp_pkg::field_t'(next_word_i);
  assign item_d.flush_request = flush_request_i;

  // Advance the input register whenever the result register is free
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  vwbp_step u_step (
    .pack_mode_i (cfg.pack_mode),
    .state_i     (state_q),
    .item_i      (item_q),
    .result_o    (res_d),
    .state_o     (state_d)
  );

  // Hold control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= vwbp_pkg::init_state(1'b1);
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg.init) begin
        state_q <= vwbp_pkg::init_state(cfg.next_pack);
      end else if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign word_out_o       = 64'(res_q.word_out);
  assign word_out_valid_o = res_q.word_out_valid;
  assign read_value_o     = 64'(res_q.read_value);
  assign word_consumed_o  = res_q.word_consumed;

endmodule

FILE: design/vwbp_apb.sv
// Configuration register port holding the pack mode.
module vwbp_apb (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [vwbp_pkg::PaddrW-1:0] paddr,
  input  vwbp_pkg::pdata_t  pwdata,
  output vwbp_pkg::pdata_t  prdata,
  output logic              pready,
  output vwbp_pkg::cfg_t    cfg_o
);

  logic               pack_mode_q;
  logic               pack_mode_d;
  logic               hit;
  logic               wr_en;
  vwbp_pkg::reg_idx_t idx;

  // Decode the register index and the write strobe
  assign idx   = paddr[vwbp_pkg::PaddrW-1:2];
  assign hit   = (idx == vwbp_pkg::RegPackMode);
  assign wr_en = psel && penable && pwrite && hit;

  assign pready      = 1'b1;
  assign pack_mode_d = wr_en ? pwdata[0] : pack_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pack_mode_q <= 1'b1;
    end else begin
      pack_mode_q <= pack_mode_d;
    end
  end

  // Read back the mode bit
  assign prdata = hit ? vwbp_pkg::pdata_t'(pack_mode_q) : '0;

  assign cfg_o.init      = wr_en;
  assign cfg_o.next_pack = pwdata[0];
  assign cfg_o.pack_mode = pack_mode_q;

endmodule

FILE: design/vwbp_step.sv
// Single-word pack and unpack step: result and next state for one word.
module vwbp_step (
  input  logic              pack_mode_i,
  input  vwbp_pkg::state_t  state_i,
  input  vwbp_pkg::item_t   item_i,
  output vwbp_pkg::result_t result_o,
  output vwbp_pkg::state_t  state_o
);

  always_comb begin
    vwbp_pkg::field_t held;
    vwbp_pkg::field_t nw;
    vwbp_pkg::field_t lo;
    vwbp_pkg::count_t pos;
    vwbp_pkg::count_t room;
    vwbp_pkg::count_t rest;
    vwbp_pkg::count_t cnt;

    held = vwbp_pkg::field_t'(state_i.bit_buffer);
    pos  = vwbp_pkg::count_t'(state_i.bit_position);
    cnt  = item_i.bit_count;
    room = vwbp_pkg::WordCount - pos;
    // Only meaningful when the count covers the free or remaining bits
    rest = cnt - room;
    nw   = item_i.next_word & vwbp_pkg::low_mask(vwbp_pkg::WordCount);
    lo   = held >> pos;

    result_o = '0;
    state_o  = state_i;

    if (pack_mode_i) begin
      if (item_i.flush_request) begin
        // Emit whatever is held, then drop back to empty
        if (pos != '0) begin
          result_o.word_out       = held & vwbp_pkg::low_mask(vwbp_pkg::WordCount);
          result_o.word_out_valid = 1'b1;
        end
        state_o = vwbp_pkg::init_state(1'b1);
      end else if (cnt > vwbp_pkg::WordCount) begin
        result_o.status = 1'b1;
      end else if (cnt >= room) begin
        // Fill the word, emit it and start the next with the leftover bits
        result_o.word_out = (held | ((item_i.write_value & vwbp_pkg::low_mask(room)) << pos))
                            & vwbp_pkg::low_mask(vwbp_pkg::WordCount);
        result_o.word_out_valid = 1'b1;
        state_o.bit_buffer   = vwbp_pkg::word_t'((item_i.write_value >> room)
                                                 & vwbp_pkg::low_mask(rest));
        state_o.bit_position = vwbp_pkg::pos_t'(rest);
      end else begin
        // Append above the held bits, at the bottom of the free space
        state_o.bit_buffer   = vwbp_pkg::word_t'(held |
                               ((item_i.write_value & vwbp_pkg::low_mask(cnt)) << pos));
        state_o.bit_position = vwbp_pkg::pos_t'(pos + cnt);
      end
    end else begin
      if (cnt > vwbp_pkg::WordCount) begin
        result_o.status = 1'b1;
      end else if (cnt >= room) begin
        // Drain the buffer, refill from the source word and take the rest
        result_o.read_value    = (lo | ((nw & vwbp_pkg::low_mask(rest)) << room))
                                 & vwbp_pkg::low_mask(cnt);
        result_o.word_consumed = 1'b1;
        state_o.bit_buffer     = vwbp_pkg::word_t'(nw);
        state_o.bit_position   = vwbp_pkg::pos_t'(rest);
      end else begin
        result_o.read_value  = lo & vwbp_pkg::low_mask(cnt);
        state_o.bit_position = vwbp_pkg::pos_t'(pos + cnt);
      end
    end
  end

endmodule

FILE: design/vwbp_checker.sv
// Port-level checks for the bit packer, bound to the top level.
module vwbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        status_o,
  input logic [63:0] word_out_o,
  input logic        word_out_valid_o,
  input logic [63:0] read_value_o,
  input logic        word_consumed_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(word_out_o) &&
    $stable(read_value_o) && $stable(status_o))
    else $error("stalled result changed");

  // An invalid count carries nothing else
  a_bad_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> word_out_o == 64'd0 && !word_out_valid_o &&
    read_value_o == 64'd0 && !word_consumed_o)
    else $error("invalid-count result carries data");

  // A packed word never comes with unpacked bits
  a_pack_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && word_out_valid_o |-> read_value_o == 64'd0 && !word_consumed_o)
    else $error("pack and unpack results mixed");

  // Input only stalls behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output back-pressure");

endmodule

bind variable_width_bit_packer vwbp_checker u_vwbp_checker (.*);

FILE: sim/variable_width_bit_packer_tb.sv
// Self-checking testbench for the variable width bit packer: packs and unpacks against a predictor.
module variable_width_bit_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [vwbp_pkg::PaddrW-1:0]   paddr;
  vwbp_pkg::pdata_t              pwdata;
  vwbp_pkg::pdata_t              prdata;
  logic                          pready;
  logic                          in_valid_i;
  logic                          in_ready_o;
  vwbp_pkg::count_t              bit_count_i;
  logic [63:0]                   write_value_i;
  logic [63:0]                   next_word_i;
  logic                          flush_request_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          status_o;
  logic [63:0]                   word_out_o;
  logic                          word_out_valid_o;
  logic [63:0]                   read_value_o;
  logic                          word_consumed_o;

  int send_gap_pct;
  int take_gap_pct;
  int quiet_cycles;

  variable_width_bit_packer uut (.*);

  // Predicts the packer word by word and holds the results still to come
  class packer_predictor;
    logic              packing;
    vwbp_pkg::word_t   word_acc;
    int                fill;
    vwbp_pkg::result_t awaited[$];
    int                faults;

    function new();
      faults = 0;
      set_mode(1'b1);
    endfunction

    // Mode write: empty the buffer, unpacking starts drained
    function void set_mode(logic pack);
      packing  = pack;
      word_acc = '0;
      fill     = pack ? 0 : vwbp_pkg::WordBits;
    endfunction

    function logic [63:0] ones_below(int n);
      return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Work out the result of one accepted word
    function void take_word(vwbp_pkg::item_t w);
      vwbp_pkg::result_t r;
      int                n;
      int                room;
      int                rest;
      logic [63:0]       v;
      logic [63:0]       got;
      r = '0;
      n = int'(w.bit_count);
      if (packing) begin
        if (w.flush_request) begin
          if (fill != 0) begin
            r.word_out       = word_acc;
            r.word_out_valid = 1'b1;
          end
          word_acc = '0;
          fill     = 0;
        end else if (n > vwbp_pkg::WordBits) begin
          r.status = 1'b1;
        end else begin
          v    = w.write_value;
          room = vwbp_pkg::WordBits - fill;
          // fill the word and spill the rest into the next one
          if (n >= room) begin
            word_acc         = word_acc | ((v & ones_below(room)) << fill);
            r.word_out       = word_acc;
            r.word_out_valid = 1'b1;
            word_acc         = '0;
            fill             = 0;
            n                = n - room;
            v                = (room >= 64) ? '0 : (v >> room);
          end
          if (n != 0) begin
            word_acc = word_acc | ((v & ones_below(n)) << fill);
            fill     = fill + n;
          end
        end
      end else if (n > vwbp_pkg::WordBits) begin
        r.status = 1'b1;
      end else begin
        got  = '0;
        rest = n;
        room = vwbp_pkg::WordBits - fill;
        // drain what is left, then refill from the supplied word
        if (n >= room) begin
          if (room != 0) got = (word_acc >> fill) & ones_below(room);
          rest            = n - room;
          fill            = 0;
          word_acc        = w.next_word;
          r.word_consumed = 1'b1;
        end
        if (rest != 0) begin
          got  = got | (((word_acc >> fill) & ones_below(rest)) << (n - rest));
          fill = fill + rest;
        end
        r.read_value = got & ones_below(n);
      end
      awaited.push_back(r);
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_field(string name, logic [63:0] exp, logic [63:0] act);
      if (exp !== act)
        note_fault($sformatf("%s mismatch: expected %h, got %h", name, exp, act));
    endfunction

    // Compare a result with the oldest expectation
    function void check_result(vwbp_pkg::result_t act);
      vwbp_pkg::result_t exp;
      if (awaited.size() == 0) begin
        note_fault($sformatf("unexpected result %p", act));
        return;
      end
      exp = awaited.pop_front();
      check_field("status", 64'(exp.status), 64'(act.status));
      check_field("word_out", exp.word_out, act.word_out);
      check_field("word_out_valid", 64'(exp.word_out_valid), 64'(act.word_out_valid));
      check_field("read_value", exp.read_value, act.read_value);
      check_field("word_consumed", 64'(exp.word_consumed), 64'(act.word_consumed));
    endfunction
  endclass

  packer_predictor model = new();

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Receiver stalls
  always @(posedge clk_i) out_ready_i <= ($urandom_range(99) >= take_gap_pct);

  // Watch both channels, feed the predictor and check results
  always @(posedge clk_i) begin
    vwbp_pkg::item_t   w;
    vwbp_pkg::result_t r;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        r.status         = status_o;
        r.word_out       = word_out_o;
        r.word_out_valid = word_out_valid_o;
        r.read_value     = read_value_o;
        r.word_consumed  = word_consumed_o;
        model.check_result(r);
      end
      if (in_valid_i && in_ready_o) begin
        w.bit_count     = bit_count_i;
        w.write_value   = write_value_i;
        w.next_word     = next_word_i;
        w.flush_request = flush_request_i;
        model.take_word(w);
      end
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("variable_width_bit_packer test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with a random gap first, and hold it until accepted
  task automatic send_word(input vwbp_pkg::item_t w);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    bit_count_i     <= w.bit_count;
    write_value_i   <= w.write_value;
    next_word_i     <= w.next_word;
    flush_request_i <= w.flush_request;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_fields(input int n, input logic [63:0] wv, input logic [63:0] nw,
                             input logic fl);
    vwbp_pkg::item_t w;
    w.bit_count     = vwbp_pkg::count_t'(n);
    w.write_value   = wv;
    w.next_word     = nw;
    w.flush_request = fl;
    send_word(w);
  endtask

  // Hold off input until every result is back, then let the pipeline empty
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (model.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input vwbp_pkg::reg_idx_t idx, input vwbp_pkg::pdata_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == vwbp_pkg::RegPackMode) model.set_mode(value[0]);
  endtask

  function automatic vwbp_pkg::item_t random_word(logic pack);
    vwbp_pkg::item_t w;
    w.write_value = {$urandom, $urandom};
    w.next_word   = {$urandom, $urandom};
    case ($urandom_range(15))
      0: w.write_value = '1;
      1: w.write_value = '0;
      2: w.next_word   = '1;
      default: ;
    endcase
    if ($urandom_range(99) < 5) begin
      w.bit_count = vwbp_pkg::count_t'($urandom_range(127, vwbp_pkg::WordBits + 1));
    end else if ($urandom_range(99) < 25) begin
      case ($urandom_range(3))
        0: w.bit_count = '0;
        1: w.bit_count = vwbp_pkg::count_t'(1);
        2: w.bit_count = vwbp_pkg::WordCount - vwbp_pkg::count_t'(1);
        default: w.bit_count = vwbp_pkg::WordCount;
      endcase
    end else begin
      w.bit_count = vwbp_pkg::count_t'($urandom_range(vwbp_pkg::WordBits));
    end
    // flushes end a packed run; in unpack mode the bit is noise
    w.flush_request = pack ? ($urandom_range(99) < 8) : 1'($urandom_range(1));
    return w;
  endfunction

  // One mode setting followed by a run of random words
  task automatic run_segment(input logic pack, input int n);
    vwbp_pkg::pdata_t v;
    settle();
    v    = $urandom;
    v[0] = pack;
    write_reg(vwbp_pkg::RegPackMode, v);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) settle();
      send_word(random_word(pack));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_valid_i      = 1'b0;
    bit_count_i     = '0;
    write_value_i   = '0;
    next_word_i     = '0;
    flush_request_i = 1'b0;
    out_ready_i     = 1'b0;
    quiet_cycles    = 0;
    send_gap_pct    = 31;
    take_gap_pct    = 47;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Packing out of reset: empty, single bits, full words, spills, invalid counts, flushes
    send_fields(0, '1, '1, 1'b0);
    send_fields(1, 64'h1, '0, 1'b0);
    send_fields(63, '1, '0, 1'b0);
    send_fields(64, 64'hA5C3_0F96_5A3C_F069, '1, 1'b0);
    send_fields(65, '1, '1, 1'b0);
    send_fields(127, '1, '1, 1'b0);
    send_fields(40, {$urandom, $urandom}, '0, 1'b0);
    send_fields(40, {$urandom, $urandom}, '0, 1'b0);
    send_fields(127, '1, '1, 1'b1);
    send_fields(0, '1, '1, 1'b1);
    send_fields(64, '1, '0, 1'b0);
    send_fields(5, 64'h15, '0, 1'b0);
    send_fields(64, 64'h8000_0000_0000_0001, '0, 1'b0);
    send_fields(0, '0, '0, 1'b1);

    // Unpacking: refill on zero count, exact fits, spans, invalid counts
    settle();
    write_reg(vwbp_pkg::RegPackMode, vwbp_pkg::pdata_t'(0));
    send_fields(0, '1, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_fields(64, '1, '1, 1'b0);
    send_fields(1, '0, '0, 1'b1);
    send_fields(63, '0, {$urandom, $urandom}, 1'b0);
    send_fields(30, '0, {$urandom, $urandom}, 1'b0);
    send_fields(50, '0, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_fields(65, '1, '1, 1'b0);
    send_fields(127, '1, '1, 1'b1);
    send_fields(64, '0, {$urandom, $urandom}, 1'b0);

    // Random phases under changing idle patterns
    run_segment(1'b1, 215);
    run_segment(1'b0, 215);
    send_gap_pct = 47;
    take_gap_pct = 31;
    run_segment(1'b0, 215);
    run_segment(1'b1, 215);
    send_gap_pct = 0;
    take_gap_pct = 0;
    run_segment(1'b1, 215);
    run_segment(1'b0, 215);

    settle();
    if (model.faults == 0 && model.pending() == 0) begin
      $display("variable_width_bit_packer test passed");
    end else begin
      $display("variable_width_bit_packer test failed");
    end
    $finish;
  end

endmodule
